[rtl/slr_pkg.sv]
// Package of shared types and constants for the slice load rebalancer.
`default_nettype none

package slr_pkg;

  localparam int unsigned HitsW     = 32;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned OwnerOutW = 4;
  localparam int unsigned CfgIdxW   = 8;

  localparam logic [CfgIdxW-1:0] RegExpandLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] RegShrinkLimit = 8'd1;

  localparam logic [HitsW-1:0] ExpandLimitRst = 32'd1000;
  localparam logic [HitsW-1:0] ShrinkLimitRst = 32'd10;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_L_OWN,
    S_L_HIT,
    S_T_RD,
    S_T_CHK,
    S_T_HALF,
    S_T_SHK,
    S_T_MIN,
    S_T_MERGE,
    S_T_ALL
  } slr_state_e;

endpackage

`default_nettype wire

[rtl/slice_load_rebalancer.sv]
// Slice-to-instance table with per-instance hit counters and a rebalancing sequencer.
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------
// in        | input     | in_valid_i / in_stall_o    | mode_i, slice_i
// out       | output    | out_valid_o / out_stall_i  | found_o, owner_o
// cfg       | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// An in-range lookup passes through the owner memory read, the hit memory read and the
// write back, and its result then sits in the output register; one lookup is in
// flight at a time, so the next item is taken only once the result has left.
// A tick walks the instances; each active instance may take a pass over the owner
// memory for a split, a least-hit search over the instances and another pass over the
// owner memory for a merge.
// After reset the owner memory is cleared in a pass over all SLICES entries, during which no
// item is accepted; configuration writes are taken at any time.
// A stalled output holds its item and blocks the next input item.

module slice_load_rebalancer
  import slr_pkg::*;
#(
  parameter int unsigned SLICES    = 256,
  parameter int unsigned INSTANCES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 mode_i,
  input  wire logic [KeyW-1:0]      slice_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      found_o,
  output logic [OwnerOutW-1:0]      owner_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [HitsW-1:0]     cfg_data_i
);

  localparam int unsigned SW = $clog2(SLICES);
  localparam int unsigned IW = $clog2(INSTANCES);
  localparam int unsigned CW = ((SW > IW) ? SW : IW) + 1;

  // Configuration registers; the user must keep the block idle when writing; not enforced.
  logic [HitsW-1:0] expand_q, shrink_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expand_q <= ExpandLimitRst;
      shrink_q <= ShrinkLimitRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegExpandLimit) expand_q <= cfg_data_i;
      if (cfg_index_i == RegShrinkLimit) shrink_q <= cfg_data_i;
    end
  end

  // Owner memory: one owning instance for each slice.
  logic [IW-1:0] owner_mem [SLICES];
  logic          om_we, om_re;
  logic [SW-1:0] om_waddr, om_raddr;
  logic [IW-1:0] om_wdata, om_rdata_q;

  always_ff @(posedge clk_i) begin
    if (om_we) owner_mem[om_waddr] <= om_wdata;
    if (om_re) om_rdata_q <= owner_mem[om_raddr];
  end

  // Hit memory. The count of an inactive instance is treated as zero, so the active bits serve
  // as valid bits and the memory itself needs no clearing.
  logic [HitsW-1:0] hits_mem [INSTANCES];
  logic             hm_we, hm_re;
  logic [IW-1:0]    hm_waddr, hm_raddr;
  logic [HitsW-1:0] hm_wdata, hm_rdata_q;

  always_ff @(posedge clk_i) begin
    if (hm_we) hits_mem[hm_waddr] <= hm_wdata;
    if (hm_re) hm_rdata_q <= hits_mem[hm_raddr];
  end

  // Control and datapath registers.
  slr_state_e       state_q, state_d;
  logic [INSTANCES-1:0] active_q, active_d;
  logic [CW-1:0]    cnt_q, cnt_d;       // sweep address counter
  logic [CW-1:0]    pa_q, pa_d;         // address of the read now returning
  logic             pv_q, pv_d;         // a sweep read is returning
  logic [IW:0]      inst_q, inst_d;     // instance under rebalance
  logic [IW-1:0]    tgt_q, tgt_d;       // instance receiving slices
  logic [IW-1:0]    who_q, who_d;       // owner found by a lookup
  logic [HitsW-1:0] hi_q, hi_d;         // hit count of the instance under rebalance
  logic [HitsW-1:0] best_q, best_d;
  logic             have_q, have_d;
  logic             seen_q, seen_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [IW-1:0]    owner_q, owner_d;

  logic          accept;
  logic [IW-1:0] inst_idx;
  logic          sweep_s_done, sweep_i_done;
  logic          free_any;
  logic [IW-1:0] free_idx;

  assign in_stall_o   = (state_q != S_IDLE) || out_valid_q;
  assign accept       = in_valid_i && !in_stall_o;
  assign inst_idx     = inst_q[IW-1:0];
  assign sweep_s_done = (cnt_q == CW'(SLICES)) && !pv_q;
  assign sweep_i_done = (cnt_q == CW'(INSTANCES)) && !pv_q;

  // Lowest inactive instance, the target of a split.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int k = INSTANCES - 1; k >= 0; k--) begin
      if (!active_q[k]) begin
        free_any = 1'b1;
        free_idx = IW'(k);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:    if (cnt_q == CW'(SLICES - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (mode_i)                          state_d = S_T_RD;
          else if (slice_i < KeyW'(SLICES))    state_d = S_L_OWN;
        end
      end
      S_L_OWN:   state_d = S_L_HIT;
      S_L_HIT:   state_d = S_IDLE;
      S_T_RD: begin
        if (inst_q == (IW + 1)'(INSTANCES)) state_d = S_IDLE;
        else if (active_q[inst_idx])         state_d = S_T_CHK;
      end
      S_T_CHK: begin
        if (hm_rdata_q > expand_q) state_d = free_any ? S_T_HALF : S_T_RD;
        else                       state_d = S_T_SHK;
      end
      S_T_HALF:  if (sweep_s_done) state_d = S_T_SHK;
      S_T_SHK:   state_d = (hi_q < shrink_q) ? S_T_MIN : S_T_RD;
      S_T_MIN:   if (sweep_i_done) state_d = S_T_MERGE;
      S_T_MERGE: state_d = have_q ? S_T_ALL : S_T_RD;
      S_T_ALL:   if (sweep_s_done) state_d = S_T_RD;
      default:   state_d = S_INIT;
    endcase
  end

  // Memory control and datapath.
  always_comb begin
    active_d    = active_q;
    cnt_d       = cnt_q;
    pa_d        = pa_q;
    pv_d        = 1'b0;
    inst_d      = inst_q;
    tgt_d       = tgt_q;
    who_d       = who_q;
    hi_d        = hi_q;
    best_d      = best_q;
    have_d      = have_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    owner_d     = owner_q;
    om_we       = 1'b0;
    om_waddr    = pa_q[SW-1:0];
    om_wdata    = tgt_q;
    om_re       = 1'b0;
    om_raddr    = cnt_q[SW-1:0];
    hm_we       = 1'b0;
    hm_waddr    = who_q;
    hm_wdata    = '0;
    hm_re       = 1'b0;
    hm_raddr    = cnt_q[IW-1:0];

    unique case (state_q)
      S_INIT: begin
        om_we    = 1'b1;
        om_waddr = cnt_q[SW-1:0];
        om_wdata = '0;
        cnt_d    = (cnt_q == CW'(SLICES - 1)) ? '0 : cnt_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          if (mode_i) begin
            inst_d = '0;
          end else if (slice_i < KeyW'(SLICES)) begin
            om_re    = 1'b1;
            om_raddr = slice_i[SW-1:0];
          end else begin
            out_valid_d = 1'b1;
            found_d     = 1'b0;
            owner_d     = '0;
          end
        end
      end
      S_L_OWN: begin
        who_d    = om_rdata_q;
        hm_re    = 1'b1;
        hm_raddr = om_rdata_q;
      end
      S_L_HIT: begin
        hm_we    = 1'b1;
        hm_waddr = who_q;
        if (!active_q[who_q])            hm_wdata = HitsW'(1);
        else if (hm_rdata_q == '1)       hm_wdata = hm_rdata_q;
        else                             hm_wdata = hm_rdata_q + 1'b1;
        active_d[who_q] = 1'b1;
        out_valid_d     = 1'b1;
        found_d         = 1'b1;
        owner_d         = who_q;
      end
      S_T_RD: begin
        if (inst_q == (IW + 1)'(INSTANCES)) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          owner_d     = '0;
        end else if (active_q[inst_idx]) begin
          hm_re    = 1'b1;
          hm_raddr = inst_idx;
        end else begin
          inst_d = inst_q + 1'b1;
        end
      end
      S_T_CHK: begin
        hi_d   = hm_rdata_q;
        cnt_d  = '0;
        seen_d = 1'b0;
        tgt_d  = free_idx;
        if ((hm_rdata_q > expand_q) && !free_any) inst_d = inst_q + 1'b1;
      end
      S_T_HALF, S_T_ALL: begin
        if (cnt_q != CW'(SLICES)) begin
          om_re = 1'b1;
          pv_d  = 1'b1;
          pa_d  = cnt_q;
          cnt_d = cnt_q + 1'b1;
        end
        if (pv_q && (om_rdata_q == inst_idx)) begin
          if (state_q == S_T_ALL) begin
            om_we = 1'b1;
          end else begin
            om_we  = seen_q;
            seen_d = !seen_q;
          end
        end
        if (sweep_s_done && (state_q == S_T_ALL)) begin
          active_d[inst_idx] = 1'b0;
          inst_d             = inst_q + 1'b1;
        end
      end
      S_T_SHK: begin
        cnt_d  = '0;
        have_d = 1'b0;
        if (!(hi_q < shrink_q)) inst_d = inst_q + 1'b1;
      end
      S_T_MIN: begin
        if (cnt_q != CW'(INSTANCES)) begin
          hm_re = 1'b1;
          pv_d  = 1'b1;
          pa_d  = cnt_q;
          cnt_d = cnt_q + 1'b1;
        end
        // Lowest index wins a tie, since only a strictly smaller count replaces it.
        if (pv_q && (pa_q[IW-1:0] != inst_idx) && active_q[pa_q[IW-1:0]] &&
            (!have_q || (hm_rdata_q < best_q))) begin
          have_d = 1'b1;
          best_d = hm_rdata_q;
          tgt_d  = pa_q[IW-1:0];
        end
      end
      S_T_MERGE: begin
        cnt_d = '0;
        if (!have_q) inst_d = inst_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      active_q    <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      inst_q      <= '0;
      have_q      <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      inst_q      <= inst_d;
      have_q      <= have_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= pa_d;
    tgt_q   <= tgt_d;
    who_q   <= who_d;
    hi_q    <= hi_d;
    best_q  <= best_d;
    found_q <= found_d;
    owner_q <= owner_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign owner_o     = OwnerOutW'(owner_q);

  // A new item is only taken once the previous result has left.
  a_accept_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !out_valid_q) else $error("item accepted while a result is pending");

  // A lookup that hits leaves its owner active.
  a_lookup_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_L_HIT) |=> active_q[$past(who_q)]) else $error("owner not active");

  // The receiver of a split is an inactive instance throughout the pass.
  a_split_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_T_HALF) |-> !active_q[tgt_q]) else $error("split target active");

  // A result without a hit carries owner zero.
  a_notfound_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (owner_o == '0)) else $error("stray owner");

endmodule

`default_nettype wire
